/* rtl/core/nst_pkg.sv */
// Shared types and codes for the named semaphore table.
`timescale 1ns / 1ps

package nst_pkg;

   // Request kinds carried on the request tuser
   localparam logic [1:0] REQ_OPEN   = 2'd0;
   localparam logic [1:0] REQ_WAIT   = 2'd1;
   localparam logic [1:0] REQ_POST   = 2'd2;
   localparam logic [1:0] REQ_UNLINK = 2'd3;

   // Result status codes carried on the response tuser
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NOENT   = 2'd2;

   // Fixed field widths
   localparam int RAW_NAME_W = 64;
   localparam int INIT_W     = 15;
   localparam int HANDLE_W   = 5;
   localparam int CNT_W      = 16;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 24;

   localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
   localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

   // Operation of the shared arithmetic unit
   typedef enum logic [1:0] {
      ALU_MATCH = 2'd0,
      ALU_DEC   = 2'd1,
      ALU_INC   = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic                    match;
      logic signed [CNT_W-1:0] cnt_next;
      logic                    block;
      logic                    wake;
   } alu_res_type;

   // Write controls from the sequencer to the table
   typedef struct packed {
      logic name_we;
      logic cnt_we;
      logic val_set;
      logic val_clr;
   } tbl_ctl_type;

endpackage

/* rtl/core/nst_alu.sv */
// Shared compare and saturating count unit.
`timescale 1ns / 1ps

module nst_alu #(
   parameter int NAME_W = 64
) (
   input  nst_pkg::alu_op_type              op,
   input  logic [NAME_W-1:0]                key_name,
   input  logic [NAME_W-1:0]                tbl_name,
   input  logic signed [nst_pkg::CNT_W-1:0] cnt,
   output nst_pkg::alu_res_type             res
);
   import nst_pkg::*;

   always_comb begin
      res          = '0;
      res.match    = (key_name == tbl_name);
      res.cnt_next = cnt;
      case (op)
         ALU_DEC: begin
            // decrement, hold at the floor
            if (cnt != CNT_MIN) begin
               res.cnt_next = cnt - 16'sd1;
            end
            res.block = res.cnt_next[CNT_W-1];
         end
         ALU_INC: begin
            // increment, hold at the ceiling
            if (cnt != CNT_MAX) begin
               res.cnt_next = cnt + 16'sd1;
            end
            res.wake = res.cnt_next[CNT_W-1] || (res.cnt_next == '0);
         end
         default: begin
            res.cnt_next = cnt;
         end
      endcase
   end

endmodule

/* rtl/core/nst_table.sv */
// Entry store: name and count memories plus per-entry valid bits.
`timescale 1ns / 1ps

module nst_table #(
   parameter int ENTRIES = 32,
   parameter int NAME_W  = 64,
   parameter int IDX_W   = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nst_pkg::tbl_ctl_type              ctl,
   input  logic [IDX_W-1:0]                  wr_addr,
   input  logic [NAME_W-1:0]                 name_wdata,
   input  logic signed [nst_pkg::CNT_W-1:0]  cnt_wdata,
   input  logic [IDX_W-1:0]                  name_raddr,
   input  logic [IDX_W-1:0]                  cnt_raddr,
   output logic [NAME_W-1:0]                 name_rdata,
   output logic signed [nst_pkg::CNT_W-1:0]  cnt_rdata,
   output logic [ENTRIES-1:0]                valid
);
   import nst_pkg::*;

   logic [NAME_W-1:0]       name_mem [ENTRIES];
   logic signed [CNT_W-1:0] cnt_mem  [ENTRIES];
   logic [NAME_W-1:0]       name_rdata_ff;
   logic signed [CNT_W-1:0] cnt_rdata_ff;
   logic [ENTRIES-1:0]      valid_ff;
   logic [ENTRIES-1:0]      valid_in;

   // Name memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctl.name_we) begin
         name_mem[wr_addr] <= name_wdata;
      end
      name_rdata_ff <= name_mem[name_raddr];
   end

   // Count memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctl.cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[cnt_raddr];
   end

   // Claim or vacate one entry
   always_comb begin
      valid_in = valid_ff;
      if (ctl.val_set) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (ctl.val_clr) begin
         valid_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign name_rdata = name_rdata_ff;
   assign cnt_rdata  = cnt_rdata_ff;
   assign valid      = valid_ff;

endmodule

/* rtl/core/named_semaphore_table_unit.sv */
// Top level of the named semaphore table: request sequencer and response register.
`timescale 1ns / 1ps
// Wait and post go from acceptance through S_CREAD (count read), S_EXEC (update) and S_RESP
// (response) to a valid response. Open and unlink scan the name memory one entry a cycle
// through a one-deep read pipeline; an empty name, or a wait or post on a vacant handle,
// goes straight to S_RESP. One request is in flight at a time: the next can be taken once
// the response is registered, and the response register lets it in while the last one waits.
// Synchronous reset clears all valid bits at once, so the table is usable right after reset.

module named_semaphore_table_unit #(
   parameter int ENTRIES    = 32,
   parameter int NAME_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = sem_name[63:0], init_count[78:64], handle[83:79], zero pad
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [nst_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request: tuser = req_type[1:0]
   input  logic [1:0]                       req_tuser,
   // response: tdata = result_handle[4:0], count_out[20:5], must_block[21],
   //                   wake_waiters[22], zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nst_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // response: tuser = status[1:0]
   output logic [1:0]                       rsp_tuser
);
   import nst_pkg::*;

   localparam int NAME_W = 8 * NAME_BYTES;
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_CREAD = 5'b00100,
      S_EXEC  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              type_ff, type_in;
   logic [NAME_W-1:0]       key_ff, key_in;
   logic [INIT_W-1:0]       init_ff, init_in;
   logic [IDX_W-1:0]        tgt_ff, tgt_in;
   logic [IDX_W-1:0]        scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]        cmp_ptr_ff, cmp_ptr_in;
   logic                    cmp_pend_ff, cmp_pend_in;
   logic                    vac_found_ff, vac_found_in;
   logic [IDX_W-1:0]        vac_ptr_ff, vac_ptr_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic [HANDLE_W-1:0]     res_handle_ff, res_handle_in;
   logic signed [CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                    res_blk_ff, res_blk_in;
   logic                    res_wake_ff, res_wake_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]              rsp_user_ff, rsp_user_in;

   logic [RAW_NAME_W-1:0]   raw_name;
   logic [RAW_NAME_W-1:0]   kept_name;
   logic [INIT_W-1:0]       req_init;
   logic [HANDLE_W-1:0]     req_handle;
   logic [IDX_W-1:0]        req_idx;
   logic                    req_hit;
   logic                    req_fire;

   tbl_ctl_type             ctl;
   logic [IDX_W-1:0]        wr_addr;
   logic signed [CNT_W-1:0] cnt_wdata;
   logic [IDX_W-1:0]        cnt_raddr;
   logic [NAME_W-1:0]       name_rdata;
   logic signed [CNT_W-1:0] cnt_rdata;
   logic [ENTRIES-1:0]      valid;

   alu_op_type              alu_op;
   alu_res_type             alu_res;

   logic                    cmp_valid;
   logic                    cmp_hit;
   logic                    vac_have;
   logic [IDX_W-1:0]        vac_idx;

   // Unpack the request
   assign raw_name   = req_tdata[RAW_NAME_W-1:0];
   assign req_init   = req_tdata[RAW_NAME_W +: INIT_W];
   assign req_handle = req_tdata[RAW_NAME_W + INIT_W +: HANDLE_W];
   assign req_idx    = IDX_W'(req_handle);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Normalise the name: keep bytes up to the first zero, within NAME_BYTES
   always_comb begin
      logic alive;
      alive     = 1'b1;
      kept_name = '0;
      for (int i = 0; i < 8; i++) begin
         if (alive && (i < NAME_BYTES) && (raw_name[8*i +: 8] != 8'd0)) begin
            kept_name[8*i +: 8] = raw_name[8*i +: 8];
         end else begin
            alive = 1'b0;
         end
      end
   end

   assign req_hit = (int'(req_handle) < ENTRIES) && valid[req_idx];

   // Scan compare on the entry read last cycle
   assign cmp_valid = valid[cmp_ptr_ff];
   assign cmp_hit   = cmp_pend_ff && cmp_valid && alu_res.match;
   assign vac_have  = vac_found_ff || !cmp_valid;
   assign vac_idx   = vac_found_ff ? vac_ptr_ff : cmp_ptr_ff;

   // Pick the shared unit's operation
   always_comb begin
      alu_op = ALU_MATCH;
      if (state_ff == S_EXEC) begin
         case (type_ff)
            REQ_WAIT: alu_op = ALU_DEC;
            REQ_POST: alu_op = ALU_INC;
            default:  alu_op = ALU_MATCH;
         endcase
      end
   end

   nst_alu #(
      .NAME_W (NAME_W)
   ) u_alu (
      .op       (alu_op),
      .key_name (key_ff),
      .tbl_name (name_rdata),
      .cnt      (cnt_rdata),
      .res      (alu_res)
   );

   nst_table #(
      .ENTRIES (ENTRIES),
      .NAME_W  (NAME_W),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .wr_addr    (wr_addr),
      .name_wdata (key_ff),
      .cnt_wdata  (cnt_wdata),
      .name_raddr (scan_ptr_ff),
      .cnt_raddr  (cnt_raddr),
      .name_rdata (name_rdata),
      .cnt_rdata  (cnt_rdata),
      .valid      (valid)
   );

   assign cnt_raddr = tgt_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      key_in        = key_ff;
      init_in       = init_ff;
      tgt_in        = tgt_ff;
      scan_ptr_in   = scan_ptr_ff;
      cmp_ptr_in    = cmp_ptr_ff;
      cmp_pend_in   = cmp_pend_ff;
      vac_found_in  = vac_found_ff;
      vac_ptr_in    = vac_ptr_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_cnt_in    = res_cnt_ff;
      res_blk_in    = res_blk_ff;
      res_wake_in   = res_wake_ff;
      ctl           = '0;
      wr_addr       = tgt_ff;
      cnt_wdata     = alu_res.cnt_next;

      // drop the response once taken
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               type_in       = req_tuser;
               key_in        = kept_name[NAME_W-1:0];
               init_in       = req_init;
               tgt_in        = req_idx;
               res_status_in = ST_OK;
               res_handle_in = '0;
               res_cnt_in    = '0;
               res_blk_in    = 1'b0;
               res_wake_in   = 1'b0;
               scan_ptr_in   = '0;
               cmp_pend_in   = 1'b0;
               vac_found_in  = 1'b0;
               if ((req_tuser == REQ_OPEN) || (req_tuser == REQ_UNLINK)) begin
                  if (kept_name[NAME_W-1:0] == '0) begin
                     res_status_in = ST_INVALID;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  res_handle_in = req_handle;
                  if (req_hit) begin
                     state_in = S_CREAD;
                  end else begin
                     res_status_in = ST_NOENT;
                     state_in      = S_RESP;
                  end
               end
            end
         end

         S_SCAN: begin
            // issue the next read while comparing the previous one
            cmp_ptr_in  = scan_ptr_ff;
            cmp_pend_in = 1'b1;
            if (scan_ptr_ff != LAST_IDX) begin
               scan_ptr_in = scan_ptr_ff + 1'b1;
            end
            // remember the lowest vacant entry
            if (cmp_pend_ff && !cmp_valid && !vac_found_ff) begin
               vac_found_in = 1'b1;
               vac_ptr_in   = cmp_ptr_ff;
            end
            if (cmp_hit) begin
               tgt_in   = cmp_ptr_ff;
               wr_addr  = cmp_ptr_ff;
               ctl.val_clr = (type_ff == REQ_UNLINK);
               state_in = S_CREAD;
            end else if (cmp_pend_ff && (cmp_ptr_ff == LAST_IDX)) begin
               state_in = S_RESP;
               if ((type_ff == REQ_OPEN) && vac_have) begin
                  // create the entry
                  wr_addr       = vac_idx;
                  cnt_wdata     = CNT_W'(init_ff);
                  ctl.name_we   = 1'b1;
                  ctl.cnt_we    = 1'b1;
                  ctl.val_set   = 1'b1;
                  res_handle_in = HANDLE_W'(vac_idx);
                  res_cnt_in    = CNT_W'(init_ff);
               end else begin
                  res_status_in = ST_NOENT;
               end
            end
         end

         S_CREAD: begin
            // count read in flight at tgt_ff
            state_in = S_EXEC;
         end

         S_EXEC: begin
            res_handle_in = HANDLE_W'(tgt_ff);
            res_cnt_in    = alu_res.cnt_next;
            if ((type_ff == REQ_WAIT) || (type_ff == REQ_POST)) begin
               ctl.cnt_we  = 1'b1;
               res_blk_in  = alu_res.block;
               res_wake_in = alu_res.wake;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {1'b0, res_wake_ff, res_blk_ff, res_cnt_ff, res_handle_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_pend_ff  <= 1'b0;
         vac_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_pend_ff  <= cmp_pend_in;
         vac_found_ff <= vac_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      key_ff        <= key_in;
      init_ff       <= init_in;
      tgt_ff        <= tgt_in;
      scan_ptr_ff   <= scan_ptr_in;
      cmp_ptr_ff    <= cmp_ptr_in;
      vac_ptr_ff    <= vac_ptr_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_cnt_ff    <= res_cnt_in;
      res_blk_ff    <= res_blk_in;
      res_wake_ff   <= res_wake_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
